// ----- rtl/hslwm_pkg.sv -----
// Shared types and constants for the hue/saturation/lightness window mask.
`default_nettype none
package hslwm_pkg;

  localparam int unsigned HUE_W   = 20;
  localparam int unsigned SAT_W   = 15;
  localparam int unsigned LIGHT_W = 17;
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 9;

  typedef logic signed [HUE_W-1:0] hue_t;

  localparam hue_t DEG60  = 20'sd60;
  localparam hue_t DEG120 = 20'sd120;
  localparam hue_t DEG240 = 20'sd240;
  localparam hue_t DEG360 = 20'sd360;
  localparam logic [SAT_W-1:0]   SAT_PERCENT   = 15'd100;
  localparam logic [LIGHT_W-1:0] LIGHT_PERCENT = 17'd100;
  localparam logic [LIGHT_W-1:0] SUM_FULL      = 17'd765;

  typedef enum logic [CFG_AW-1:0] {
    CFG_HUE_CENTER     = 3'd0,
    CFG_HUE_HALF_WIDTH = 3'd1,
    CFG_SAT_UPPER      = 3'd2,
    CFG_SAT_LOWER      = 3'd3,
    CFG_LIGHT_UPPER    = 3'd4,
    CFG_LIGHT_LOWER    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BR_RED,
    BR_GREEN,
    BR_BLUE
  } branch_e;

  // blue in the lowest bits
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [8:0] hue_center;
    logic [8:0] hue_half_width;
    logic [6:0] sat_upper;
    logic [6:0] sat_lower;
    logic [6:0] light_upper;
    logic [6:0] light_lower;
  } cfg_t;

  typedef struct packed {
    pixel_t          pix;
    logic            gray;
    branch_e         branch;
    logic signed [8:0] diff;
    logic [7:0]      mx;
    logic [7:0]      dlt;
    logic [SUM_W-1:0] sum;
  } s1_t;

  typedef struct packed {
    pixel_t             pix;
    logic               gray;
    hue_t               num;
    hue_t               full_turn;
    hue_t               hi_bound;
    hue_t               lo_bound;
    logic [SAT_W-1:0]   sat_num;
    logic [SAT_W-1:0]   sat_hi;
    logic [SAT_W-1:0]   sat_lo;
    logic [LIGHT_W-1:0] light_num;
    logic [LIGHT_W-1:0] light_hi;
    logic [LIGHT_W-1:0] light_lo;
  } s2_t;

endpackage
`default_nettype wire

// ----- rtl/hslwm_cfg.sv -----
// Configuration register file for the window bounds.
`default_nettype none
module hslwm_cfg
  import hslwm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_HUE_CENTER:     cfg_d.hue_center     = cfg_data_i;
        CFG_HUE_HALF_WIDTH: cfg_d.hue_half_width = cfg_data_i;
        CFG_SAT_UPPER:      cfg_d.sat_upper      = cfg_data_i[6:0];
        CFG_SAT_LOWER:      cfg_d.sat_lower      = cfg_data_i[6:0];
        CFG_LIGHT_UPPER:    cfg_d.light_upper    = cfg_data_i[6:0];
        CFG_LIGHT_LOWER:    cfg_d.light_lower    = cfg_data_i[6:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_center     <= 9'd180;
      cfg_q.hue_half_width <= 9'd180;
      cfg_q.sat_upper      <= 7'd100;
      cfg_q.sat_lower      <= 7'd0;
      cfg_q.light_upper    <= 7'd100;
      cfg_q.light_lower    <= 7'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hslwm_minmax.sv -----
// Stage 1: max, min, hue branch and channel sum.
`default_nettype none
module hslwm_minmax
  import hslwm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  output logic        ready_o,
  input  wire pixel_t pix_i,
  output logic        valid_o,
  input  wire logic   ready_i,
  output s1_t         data_o
);

  logic   valid_q;
  s1_t    data_q, data_d;
  logic [7:0] mx, mn;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    mx = pix_i.blue;
    mn = pix_i.blue;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.red > mx)   mx = pix_i.red;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.red < mn)   mn = pix_i.red;

    data_d.pix  = pix_i;
    data_d.mx   = mx;
    data_d.dlt  = mx - mn;
    data_d.gray = (mx == mn);
    data_d.sum  = SUM_W'(pix_i.blue) + SUM_W'(pix_i.green) + SUM_W'(pix_i.red);
    priority if (pix_i.blue == mx) begin
      data_d.branch = BR_BLUE;
      data_d.diff   = $signed({1'b0, pix_i.red}) - $signed({1'b0, pix_i.green});
    end else if (pix_i.green == mx) begin
      data_d.branch = BR_GREEN;
      data_d.diff   = $signed({1'b0, pix_i.blue}) - $signed({1'b0, pix_i.red});
    end else begin
      data_d.branch = BR_RED;
      data_d.diff   = $signed({1'b0, pix_i.green}) - $signed({1'b0, pix_i.blue});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hslwm_product.sv -----
// Stage 2: hue numerator and all cross-multiplied bound products.
`default_nettype none
module hslwm_product
  import hslwm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire s1_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output s2_t       data_o
);

  logic valid_q;
  s2_t  data_q, data_d;
  hue_t dlt_h, diff_h, base, hi_h, lo_h;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    dlt_h  = hue_t'(data_i.dlt);
    diff_h = hue_t'(data_i.diff);
    hi_h   = hue_t'(cfg_i.hue_center) + hue_t'(cfg_i.hue_half_width);
    lo_h   = hue_t'(cfg_i.hue_center) - hue_t'(cfg_i.hue_half_width);
    unique case (data_i.branch)
      BR_BLUE:  base = DEG240;
      BR_GREEN: base = DEG120;
      default:  base = '0;
    endcase

    data_d.pix       = data_i.pix;
    data_d.gray      = data_i.gray;
    data_d.num       = diff_h * DEG60 + base * dlt_h;
    data_d.full_turn = DEG360 * dlt_h;
    data_d.hi_bound  = hi_h * dlt_h;
    data_d.lo_bound  = lo_h * dlt_h;
    data_d.sat_num   = SAT_W'(data_i.dlt) * SAT_PERCENT;
    data_d.sat_hi    = SAT_W'(cfg_i.sat_upper) * SAT_W'(data_i.mx);
    data_d.sat_lo    = SAT_W'(cfg_i.sat_lower) * SAT_W'(data_i.mx);
    data_d.light_num = LIGHT_W'(data_i.sum) * LIGHT_PERCENT;
    data_d.light_hi  = LIGHT_W'(cfg_i.light_upper) * SUM_FULL;
    data_d.light_lo  = LIGHT_W'(cfg_i.light_lower) * SUM_FULL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hslwm_decide.sv -----
// Stage 3: window compares and masked output register.
`default_nettype none
module hslwm_decide
  import hslwm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      ready_o,
  input  wire s2_t  data_i,
  output logic      valid_o,
  input  wire logic ready_i,
  output pixel_t    pix_o,
  output logic      kept_o
);

  logic   valid_q;
  pixel_t pix_q, pix_d;
  logic   kept_q, kept_d;
  hue_t   hue;
  logic   hue_ok, sat_ok, light_ok;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign kept_o  = kept_q;

  always_comb begin
    hue      = (data_i.num < 0) ? data_i.num + data_i.full_turn : data_i.num;
    hue_ok   = !(hue > data_i.hi_bound) && !(hue < data_i.lo_bound);
    sat_ok   = !(data_i.sat_num > data_i.sat_hi) && !(data_i.sat_num < data_i.sat_lo);
    light_ok = !(data_i.light_num > data_i.light_hi)
            && !(data_i.light_num < data_i.light_lo);
    kept_d   = !data_i.gray && hue_ok && sat_ok && light_ok;
    pix_d    = kept_d ? data_i.pix : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pix_q  <= pix_d;
      kept_q <= kept_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hue_sat_light_window_mask.sv -----
// Top level of the hue/saturation/lightness window mask.
// One pixel per clock while the output is not stalled; each pixel passes through three
// register stages (max/min, bound products, compares and output). Stages hold independently,
// so a stalled output only backs up the stages behind it. A pixel is passed when hue,
// saturation and lightness all lie in their inclusive windows, else zeroed; gray pixels are
// always zeroed and the hue window does not wrap. Configuration writes are taken every cycle
// and must be made while no pixel is in flight.
`default_nettype none
module hue_sat_light_window_mask
  import hslwm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [23:0]       s_axis_tdata,  // in_blue, in_green, in_red
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [23:0]            m_axis_tdata,  // out_blue, out_green, out_red
  output logic [0:0]             m_axis_tuser,  // pixel_kept
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CFG_AW-1:0] cfg_addr_i,
  input  wire logic [CFG_DW-1:0] cfg_data_i
);

  cfg_t   cfg;
  logic   s1_valid, s1_ready, s2_valid, s2_ready;
  s1_t    s1_data;
  s2_t    s2_data;
  pixel_t out_pix;
  logic   out_kept;

  hslwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hslwm_minmax u_minmax (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pix_i   (pixel_t'(s_axis_tdata)),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  hslwm_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  hslwm_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .pix_o   (out_pix),
    .kept_o  (out_kept)
  );

  assign m_axis_tdata = out_pix;
  assign m_axis_tuser = out_kept;

endmodule
`default_nettype wire
